### hw/rtl/itr_pkg.sv
// Package for the integer to radix text converter.
// Holds the radix limits, character codes, the sequencer state type and the
// result beat type. It depends on nothing else.
`default_nettype none

package itr_pkg;

  localparam int unsigned RADIX_W = 6;
  localparam int unsigned CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DECIMAL     = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOAD,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
    logic              error;
  } out_beat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] digit);
    logic [CHAR_W-1:0] d7;
    d7 = {1'b0, digit};
    if (digit < DECIMAL) begin
      return CHAR_ZERO + d7;
    end else begin
      return CHAR_A + d7 - {1'b0, DECIMAL};
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/itr_value_if.sv
// Input channel carrying one signed integer per beat.
// Depends on nothing else.
`default_nettype none

interface itr_value_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### hw/rtl/itr_char_if.sv
// Output channel carrying one text character per beat with its flags.
// Depends on nothing else.
`default_nettype none

interface itr_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last;
  logic       error;

  modport source (output valid, output char_code, output last, output error, input ready);
  modport sink   (input valid, input char_code, input last, input error, output ready);
endinterface

`default_nettype wire

### hw/rtl/itr_cfg_if.sv
// Configuration write channel carrying the radix register's write data.
// Depends on nothing else.
`default_nettype none

interface itr_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

`default_nettype wire

### hw/rtl/itr_div.sv
// Bit-serial restoring divider of an unsigned word by a 6-bit radix.
// One quotient bit per cycle. Depends on itr_pkg.
`default_nettype none

module itr_div
  import itr_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [RADIX_W-1:0]     divisor_i,
  output logic                        done_o,
  output logic [VALUE_WIDTH-1:0]      quotient_o,
  output logic [RADIX_W-1:0]          remainder_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [RADIX_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [RADIX_W:0]       trial;
  logic [RADIX_W:0]       diff;
  logic                   fits;

  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(VALUE_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_WIDTH-2:0], fits};
      rem_d = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

### hw/rtl/integer_to_radix_text_top.sv
// Top level of the integer to radix text converter.
// Depends on itr_pkg, the three channel interfaces and itr_div.
//
// Usage: write the radix (2 to 36, reset value 10) on cfg_if while the block
// is idle; cfg_if.ready is always high. Each beat accepted on in_if carries a
// signed integer, and out_if then delivers its text one character per beat,
// most significant digit first, with last set on the final character. In
// radix 10 a negative value starts with a minus sign; other radices convert
// the raw bit pattern as unsigned. A radix outside 2 to 36 gives a single beat
// with error and last set and a character code of zero.
// Timing: in_if.ready is high only while idle. Each digit takes one pass of
// the shared bit-serial divider, and all digits of an item are converted
// before its first character is emitted.
// The next item can be accepted in the cycle after the last character leaves.
// Reset returns the sequencer to idle and the radix to 10. When the receiver
// stalls, the pending character is held stable and the remaining characters wait.
`default_nettype none

module integer_to_radix_text_top
  import itr_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  itr_value_if.sink  in_if,
  itr_char_if.source out_if,
  itr_cfg_if.sink    cfg_if
);

  localparam int unsigned AW = $clog2(VALUE_WIDTH);
  localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

  state_e                 state_q, state_d;
  logic [RADIX_W-1:0]     radix_q;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   minus_q, minus_d;
  out_beat_t              out_q, out_d;
  logic [RADIX_W-1:0]     rd_q;
  logic [RADIX_W-1:0]     digit_mem [VALUE_WIDTH];

  logic                   radix_ok;
  logic                   negative;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quotient;
  logic [RADIX_W-1:0]     div_remainder;
  logic                   mem_we;
  logic [CW-1:0]          rd_ptr;

  assign radix_ok = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);
  assign negative = (radix_q == DECIMAL) && in_if.value[VALUE_WIDTH-1];
  assign mag_in   = negative ? (~in_if.value + 1'b1) : in_if.value;
  assign rd_ptr   = cnt_q - 1'b1;

  itr_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (radix_q),
    .done_o     (div_done),
    .quotient_o (div_quotient),
    .remainder_o(div_remainder)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    minus_d      = minus_q;
    out_d        = out_q;
    div_start    = 1'b0;
    div_dividend = div_quotient;
    mem_we       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          if (!radix_ok) begin
            out_d   = '{char_code: CHAR_NONE, last: 1'b1, error: 1'b1};
            state_d = ST_SEND;
          end else begin
            minus_d      = negative;
            div_start    = 1'b1;
            div_dividend = mag_in;
            cnt_d        = '0;
            state_d      = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          if (div_quotient != '0) begin
            div_start = 1'b1;
          end else if (minus_q) begin
            out_d   = '{char_code: CHAR_MINUS, last: 1'b0, error: 1'b0};
            state_d = ST_SEND;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        cnt_d   = rd_ptr;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        out_d   = '{char_code: digit_char(rd_q), last: (cnt_q == '0), error: 1'b0};
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (out_if.ready) begin
          state_d = out_q.last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      radix_q <= RADIX_RESET;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_if.valid) begin
        radix_q <= cfg_if.radix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    minus_q <= minus_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[cnt_q[AW-1:0]] <= div_remainder;
    end
    rd_q <= digit_mem[rd_ptr[AW-1:0]];
  end

  assign in_if.ready      = (state_q == ST_IDLE);
  assign cfg_if.ready     = 1'b1;
  assign out_if.valid     = (state_q == ST_SEND);
  assign out_if.char_code = out_q.char_code;
  assign out_if.last      = out_q.last;
  assign out_if.error     = out_q.error;

endmodule

`default_nettype wire
